### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define RME_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// Check that a condition never holds outside reset.
`define RME_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define RME_ASSERT(lbl, clk, rstn, prop)
`define RME_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### sv/rme_pkg.sv
// Types, constants and helper functions for the Euler angle extractor.
package rme_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_EXTRA    = 8;
  localparam int W             = 30;   // datapath width of vector components
  localparam int AW            = 33;   // angle accumulator width, Q2.30
  localparam int PW            = W + 32;
  localparam int THR_W         = 10;
  localparam int OUT_W         = 15;
  localparam int SQ_W          = 19;   // clamped magnitude for the null check

  localparam logic signed [31:0] KINV_Q30 = 32'sd652032874;
  localparam logic signed [OUT_W-1:0] HALF_PI_Q13 = 15'sd12868;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_X1_LOW  = 3'd1;
  localparam logic [2:0] ST_XY_NULL = 3'd2;
  localparam logic [2:0] ST_X2_LOW  = 3'd3;
  localparam logic [2:0] ST_XZ_NULL = 3'd4;
  localparam logic [2:0] ST_YZ_NULL = 3'd5;

  typedef logic signed [W-1:0]  val_t;
  typedef logic signed [AW-1:0] ang_t;
  typedef logic signed [PW-1:0] prod_t;

  // data that rides along a CORDIC pass untouched
  typedef struct packed {
    logic [2:0] status;
    val_t       z;
    val_t       r;
    val_t       q;
    ang_t       angz;
    ang_t       angy;
  } side_t;

  // arctangent of 2^-s in Q2.30, truncated
  function automatic ang_t atan_q30(input int s);
    ang_t v;
    unique case (s)
      0: v = 33'sd843314856;
      1: v = 33'sd497837829;
      2: v = 33'sd263043836;
      3: v = 33'sd133525158;
      4: v = 33'sd67021686;
      5: v = 33'sd33543515;
      6: v = 33'sd16775850;
      7: v = 33'sd8388437;
      8: v = 33'sd4194282;
      9: v = 33'sd2097149;
      10: v = 33'sd1048575;
      11: v = 33'sd524287;
      12: v = 33'sd262143;
      13: v = 33'sd131071;
      14: v = 33'sd65535;
      15: v = 33'sd32767;
      16: v = 33'sd16383;
      17: v = 33'sd8191;
      18: v = 33'sd4095;
      19: v = 33'sd2047;
      20: v = 33'sd1023;
      21: v = 33'sd511;
      22: v = 33'sd255;
      23: v = 33'sd127;
      24: v = 33'sd63;
      25: v = 33'sd31;
      26: v = 33'sd15;
      27: v = 33'sd7;
      28: v = 33'sd3;
      29: v = 33'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round a Q30 product back to the datapath scale, floor after adding half
  function automatic val_t round_q30(input prod_t v);
    prod_t t;
    t = (v + (prod_t'(1) <<< 29)) >>> 30;
    return t[W-1:0];
  endfunction

  // Q2.30 angle to Q1.13, rounded and clamped to a quarter turn
  function automatic logic signed [OUT_W-1:0] to_q13(input ang_t a);
    ang_t t;
    logic signed [OUT_W-1:0] r;
    t = (a + ang_t'(65536)) >>> 17;
    if (t > ang_t'(HALF_PI_Q13)) begin
      r = HALF_PI_Q13;
    end else if (t < -ang_t'(HALF_PI_Q13)) begin
      r = -HALF_PI_Q13;
    end else begin
      r = t[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/rme_cordic.sv
// Pipelined CORDIC vectoring pass: one micro-rotation per register stage.
module rme_cordic (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  rme_pkg::val_t x_i,
  input  rme_pkg::val_t y_i,
  input  rme_pkg::val_t p_i,
  input  rme_pkg::val_t q_i,
  input  rme_pkg::side_t side_i,
  output logic          valid_o,
  output rme_pkg::val_t x_o,
  output rme_pkg::val_t y_o,
  output rme_pkg::val_t p_o,
  output rme_pkg::val_t q_o,
  output rme_pkg::ang_t ang_o,
  output rme_pkg::side_t side_o
);
  import rme_pkg::*;

  // stage inputs; index 0 is the module input
  logic  vld_s  [CORDIC_STAGES+1];
  val_t  x_s    [CORDIC_STAGES+1];
  val_t  y_s    [CORDIC_STAGES+1];
  val_t  p_s    [CORDIC_STAGES+1];
  val_t  q_s    [CORDIC_STAGES+1];
  ang_t  ang_s  [CORDIC_STAGES+1];
  side_t side_s [CORDIC_STAGES+1];

  assign vld_s[0]  = valid_i;
  assign x_s[0]    = x_i;
  assign y_s[0]    = y_i;
  assign p_s[0]    = p_i;
  assign q_s[0]    = q_i;
  assign ang_s[0]  = '0;
  assign side_s[0] = side_i;

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    logic  vld_q;
    val_t  x_q, y_q, p_q, q_q;
    ang_t  ang_q;
    side_t side_q;
    logic  cw;

    // turn clockwise while the driven component is not negative
    assign cw = (y_s[s] >= 0);

    // advance the valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_s[s];
      end
    end

    // rotate by +-atan(2^-s)
    always_ff @(posedge clk_i) begin
      side_q <= side_s[s];
      if (cw) begin
        x_q   <= x_s[s] + (y_s[s] >>> s);
        y_q   <= y_s[s] - (x_s[s] >>> s);
        p_q   <= p_s[s] + (q_s[s] >>> s);
        q_q   <= q_s[s] - (p_s[s] >>> s);
        ang_q <= ang_s[s] + atan_q30(s);
      end else begin
        x_q   <= x_s[s] - (y_s[s] >>> s);
        y_q   <= y_s[s] + (x_s[s] >>> s);
        p_q   <= p_s[s] - (q_s[s] >>> s);
        q_q   <= q_s[s] + (p_s[s] >>> s);
        ang_q <= ang_s[s] - atan_q30(s);
      end
    end

    assign vld_s[s+1]  = vld_q;
    assign x_s[s+1]    = x_q;
    assign y_s[s+1]    = y_q;
    assign p_s[s+1]    = p_q;
    assign q_s[s+1]    = q_q;
    assign ang_s[s+1]  = ang_q;
    assign side_s[s+1] = side_q;
  end

  assign valid_o = vld_s[CORDIC_STAGES];
  assign x_o     = x_s[CORDIC_STAGES];
  assign y_o     = y_s[CORDIC_STAGES];
  assign p_o     = p_s[CORDIC_STAGES];
  assign q_o     = q_s[CORDIC_STAGES];
  assign ang_o   = ang_s[CORDIC_STAGES];
  assign side_o  = side_s[CORDIC_STAGES];

endmodule

### sv/rotation_matrix_to_euler_xyz.sv
// Top level of the Euler angle extractor (x, y, z order).
//
// Usage: drive the first and third matrix columns (Q1.14) on the col*_i
// ports and pulse start. busy is always low, so an item is taken in every
// cycle that start is high: one item per clock cycle, sustained.
// Each item yields exactly one result on angle_x_o, angle_y_o, angle_z_o
// (Q1.13 radians) and status_o, marked by done_o for one cycle. The
// pipeline is three CORDIC chains of 16 stages each, two Q30 rescale
// steps of two stages, the length check of two stages, one input and
// one output stage.
// The receiver cannot stall: results come in the order items went in.
// A failed check gives a nonzero status and zero angles.
// near_zero_threshold sits at APB address 0 and resets to 1; write it
// only while no items are in flight. Reset clears all valid bits, so
// items in flight at reset are dropped.
module rotation_matrix_to_euler_xyz (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] col1_x_i,
  input  logic signed [15:0] col1_y_i,
  input  logic signed [15:0] col1_z_i,
  input  logic signed [15:0] col3_x_i,
  input  logic signed [15:0] col3_y_i,
  input  logic signed [15:0] col3_z_i,
  output logic        done_o,
  output logic signed [14:0] angle_x_o,
  output logic signed [14:0] angle_y_o,
  output logic signed [14:0] angle_z_o,
  output logic [2:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rme_pkg::*;
  `include "assert_macros.svh"

  // configuration register
  logic [THR_W-1:0] thr_q;
  logic [17:0]      big;
  logic [35:0]      big_sq;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign prdata = paddr[2] ? 32'd0 : {22'd0, thr_q};
  assign big    = {thr_q, 8'd0};
  assign big_sq = 36'(big) * 36'(big);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 10'd1;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  // input stage: widen and run the column 1 x check
  logic  s0_vld_q;
  val_t  s0_x_q, s0_y_q, s0_p_q, s0_q_q;
  side_t s0_side_q, s0_side_d;
  logic  s0_fail;

  assign s0_fail = (17'(col1_x_i) < $signed({7'd0, thr_q}));

  always_comb begin
    s0_side_d        = '0;
    s0_side_d.z      = val_t'(col1_z_i) <<< FRAC_EXTRA;
    s0_side_d.r      = val_t'(col3_z_i) <<< FRAC_EXTRA;
    s0_side_d.status = s0_fail ? ST_X1_LOW : ST_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_x_q    <= val_t'(col1_x_i) <<< FRAC_EXTRA;
    s0_y_q    <= val_t'(col1_y_i) <<< FRAC_EXTRA;
    s0_p_q    <= val_t'(col3_x_i) <<< FRAC_EXTRA;
    s0_q_q    <= val_t'(col3_y_i) <<< FRAC_EXTRA;
    s0_side_q <= s0_side_d;
  end

  // pass one: turn column 1 into the xz plane
  logic  c1_vld;
  val_t  c1_x, c1_p, c1_q;
  ang_t  c1_ang;
  side_t c1_side;

  rme_cordic u_pass_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_vld_q),
    .x_i     (s0_x_q),
    .y_i     (s0_y_q),
    .p_i     (s0_p_q),
    .q_i     (s0_q_q),
    .side_i  (s0_side_q),
    .valid_o (c1_vld),
    .x_o     (c1_x),
    .y_o     (),
    .p_o     (c1_p),
    .q_o     (c1_q),
    .ang_o   (c1_ang),
    .side_o  (c1_side)
  );

  // rescale pass one results: multiply
  logic  u1_vld_q;
  prod_t u1_x_q, u1_p_q, u1_q_q;
  side_t u1_side_q, u1_side_d;

  always_comb begin
    u1_side_d      = c1_side;
    u1_side_d.angz = c1_ang;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u1_vld_q <= 1'b0;
    end else begin
      u1_vld_q <= c1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    u1_x_q    <= prod_t'(c1_x) * prod_t'(KINV_Q30);
    u1_p_q    <= prod_t'(c1_p) * prod_t'(KINV_Q30);
    u1_q_q    <= prod_t'(c1_q) * prod_t'(KINV_Q30);
    u1_side_q <= u1_side_d;
  end

  // rescale pass one results: round, then check x after the z turn
  logic  u2_vld_q;
  val_t  u2_x_q, u2_p_q;
  side_t u2_side_q, u2_side_d;
  val_t  u2_x;

  assign u2_x = round_q30(u1_x_q);

  always_comb begin
    u2_side_d   = u1_side_q;
    u2_side_d.q = round_q30(u1_q_q);
    if (u1_side_q.status == ST_OK && u2_x < val_t'(big)) begin
      u2_side_d.status = ST_X2_LOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u2_vld_q <= 1'b0;
    end else begin
      u2_vld_q <= u1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    u2_x_q    <= u2_x;
    u2_p_q    <= round_q30(u1_p_q);
    u2_side_q <= u2_side_d;
  end

  // pass two: turn column 1 onto the x axis
  logic  c2_vld;
  val_t  c2_r;
  ang_t  c2_ang;
  side_t c2_side;

  rme_cordic u_pass_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (u2_vld_q),
    .x_i     (u2_x_q),
    .y_i     (u2_side_q.z),
    .p_i     (u2_p_q),
    .q_i     (u2_side_q.r),
    .side_i  (u2_side_q),
    .valid_o (c2_vld),
    .x_o     (),
    .y_o     (),
    .p_o     (),
    .q_o     (c2_r),
    .ang_o   (c2_ang),
    .side_o  (c2_side)
  );

  // rescale the z component of column 3
  logic  u3_vld_q;
  prod_t u3_r_q;
  side_t u3_side_q, u3_side_d;

  always_comb begin
    u3_side_d      = c2_side;
    u3_side_d.angy = c2_ang;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u3_vld_q <= 1'b0;
    end else begin
      u3_vld_q <= c2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    u3_r_q    <= prod_t'(c2_r) * prod_t'(KINV_Q30);
    u3_side_q <= u3_side_d;
  end

  logic  u4_vld_q;
  side_t u4_side_q, u4_side_d;

  always_comb begin
    u4_side_d   = u3_side_q;
    u4_side_d.r = round_q30(u3_r_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u4_vld_q <= 1'b0;
    end else begin
      u4_vld_q <= u3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    u4_side_q <= u4_side_d;
  end

  // square the clamped magnitudes of column 3's y and z
  logic [SQ_W-1:0]   mag_q, mag_r;
  logic [W-1:0]      abs_q, abs_r;
  logic              sq_vld_q;
  logic [2*SQ_W-1:0] sq_q_q, sq_r_q;
  side_t             sq_side_q;

  assign abs_q = u4_side_q.q[W-1] ? W'(-u4_side_q.q) : W'(u4_side_q.q);
  assign abs_r = u4_side_q.r[W-1] ? W'(-u4_side_q.r) : W'(u4_side_q.r);
  assign mag_q = (abs_q >= W'(1 << (SQ_W - 1))) ? SQ_W'(1 << (SQ_W - 1))
                                                : abs_q[SQ_W-1:0];
  assign mag_r = (abs_r >= W'(1 << (SQ_W - 1))) ? SQ_W'(1 << (SQ_W - 1))
                                                : abs_r[SQ_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= u4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q_q    <= (2*SQ_W)'(mag_q) * (2*SQ_W)'(mag_q);
    sq_r_q    <= (2*SQ_W)'(mag_r) * (2*SQ_W)'(mag_r);
    sq_side_q <= u4_side_q;
  end

  // check the yz length of column 3
  logic  ck_vld_q;
  side_t ck_side_q, ck_side_d;
  logic [2*SQ_W:0] sq_sum;

  assign sq_sum = (2*SQ_W+1)'(sq_q_q) + (2*SQ_W+1)'(sq_r_q);

  always_comb begin
    ck_side_d = sq_side_q;
    if (sq_side_q.status == ST_OK && sq_sum < (2*SQ_W+1)'(big_sq)) begin
      ck_side_d.status = ST_YZ_NULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ck_vld_q <= 1'b0;
    end else begin
      ck_vld_q <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ck_side_q <= ck_side_d;
  end

  // pass three: angle left in column 3
  logic  c3_vld;
  ang_t  c3_ang;
  side_t c3_side;

  rme_cordic u_pass_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ck_vld_q),
    .x_i     (ck_side_q.r),
    .y_i     (ck_side_q.q),
    .p_i     ('0),
    .q_i     ('0),
    .side_i  (ck_side_q),
    .valid_o (c3_vld),
    .x_o     (),
    .y_o     (),
    .p_o     (),
    .q_o     (),
    .ang_o   (c3_ang),
    .side_o  (c3_side)
  );

  // output stage: pick rx, scale angles, zero them on failure
  logic signed [OUT_W-1:0] ax;

  always_comb begin
    if (c3_side.q == '0) begin
      ax = '0;
    end else if (c3_side.r <= 0) begin
      ax = (c3_side.q > 0) ? -HALF_PI_Q13 : HALF_PI_Q13;
    end else begin
      ax = -to_q13(c3_ang);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= c3_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    status_o <= c3_side.status;
    if (c3_side.status == ST_OK) begin
      angle_x_o <= ax;
      angle_y_o <= to_q13(-c3_side.angy);
      angle_z_o <= to_q13(c3_side.angz);
    end else begin
      angle_x_o <= '0;
      angle_y_o <= '0;
      angle_z_o <= '0;
    end
  end

  `RME_ASSERT(a_fail_zero, clk_i, rst_ni,
    (done_o && status_o != ST_OK) |-> (angle_x_o == 0 && angle_y_o == 0 && angle_z_o == 0))
  `RME_ASSERT(a_ax_range, clk_i, rst_ni,
    done_o |-> (angle_x_o <= HALF_PI_Q13 && angle_x_o >= -HALF_PI_Q13))
  `RME_ASSERT_NEVER(a_len_codes, clk_i, rst_ni,
    done_o && (status_o == ST_XY_NULL || status_o == ST_XZ_NULL))

endmodule

### bench/testbench.sv
// Self-checking testbench for the rotation matrix to Euler angle extractor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rme_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [2:0] ADDR_THRESHOLD = 3'd0;

  typedef struct packed {
    logic signed [14:0] ang_x;
    logic signed [14:0] ang_y;
    logic signed [14:0] ang_z;
    logic [2:0]         status;
  } angles_t;

  typedef struct {
    logic signed [15:0] m [6];
    bit                 known;
    logic [2:0]         status;
  } dir_row_t;

  logic clk_i, rst_ni, start, busy, done_o, psel, penable, pwrite, pready;
  logic signed [15:0] col1_x_i, col1_y_i, col1_z_i, col3_x_i, col3_y_i, col3_z_i;
  logic signed [14:0] angle_x_o, angle_y_o, angle_z_o;
  logic [2:0]  status_o, paddr;
  logic [31:0] pwdata, prdata;

  angles_t   expected_angles [$];
  logic [9:0] thr_model;
  int  errors = 0;
  int  quiet_cycles = 0;
  bit  no_idle = 0;

  rotation_matrix_to_euler_xyz i_dut (.*);

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // CORDIC vectoring pass: drive y to zero, turn (p, q) alike, return angle in Q2.30
  function automatic longint cordic_vector(inout longint x, y, p, q);
    longint ang, dx, dy, dp, dq;
    longint atan_q [16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                            33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                            524287, 262143, 131071, 65535, 32767};
    ang = 0;
    for (int s = 0; s < 16; s++) begin
      dx = y >>> s; dy = x >>> s; dp = q >>> s; dq = p >>> s;
      if (y >= 0) begin
        x += dx; y -= dy; p += dp; q -= dq; ang += atan_q[s];
      end else begin
        x -= dx; y += dy; p -= dp; q += dq; ang -= atan_q[s];
      end
    end
    return ang;
  endfunction

  function automatic longint gain_fix(longint v);
    return (v * 64'sd652032874 + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint rad_q13(longint a);
    longint r;
    r = (a + 65536) >>> 17;
    if (r > 12868) r = 12868;
    if (r < -12868) r = -12868;
    return r;
  endfunction

  // Predict the angles of one matrix under the current threshold
  function automatic angles_t predict_angles(logic signed [15:0] m [6]);
    angles_t res;
    longint i, j, k, a, b, c, t, big, x, y, z, p, q, r, az, ay, d1, d2;
    i = m[0]; j = m[1]; k = m[2]; a = m[3]; b = m[4]; c = m[5];
    t = thr_model;
    big = t * 256;
    res = '0;
    res.status = ST_OK;
    if (i < t) begin
      res.status = ST_X1_LOW;
    end else if (i * i + j * j < t * t) begin
      res.status = ST_XY_NULL;
    end else begin
      x = i * 256; y = j * 256; z = k * 256; p = a * 256; q = b * 256; r = c * 256;
      az = cordic_vector(x, y, p, q);
      x = gain_fix(x); p = gain_fix(p); q = gain_fix(q);
      if (x < big) begin
        res.status = ST_X2_LOW;
      end else if (x * x + z * z < big * big) begin
        res.status = ST_XZ_NULL;
      end else begin
        ay = cordic_vector(x, z, p, r);
        p = gain_fix(p); r = gain_fix(r);
        if (q * q + r * r < big * big) begin
          res.status = ST_YZ_NULL;
        end else begin
          if (q == 0) res.ang_x = '0;
          else if (r <= 0) res.ang_x = (q > 0) ? -15'sd12868 : 15'sd12868;
          else begin
            d1 = 0; d2 = 0;
            res.ang_x = 15'(-rad_q13(cordic_vector(r, q, d1, d2)));
          end
          res.ang_y = 15'(rad_q13(-ay));
          res.ang_z = 15'(rad_q13(az));
        end
      end
    end
    return res;
  endfunction

  // Check each result against the oldest expectation; watch for a hang
  always @(posedge clk_i) begin
    if (done_o) begin
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d st=%0d", $time,
                 angle_x_o, angle_y_o, angle_z_o, status_o);
        errors++;
      end else begin
        angles_t e;
        e = expected_angles.pop_front();
        if (angle_x_o !== e.ang_x) begin
          $display("%0t: angle_x expected %0d got %0d", $time, e.ang_x, angle_x_o); errors++;
        end
        if (angle_y_o !== e.ang_y) begin
          $display("%0t: angle_y expected %0d got %0d", $time, e.ang_y, angle_y_o); errors++;
        end
        if (angle_z_o !== e.ang_z) begin
          $display("%0t: angle_z expected %0d got %0d", $time, e.ang_z, angle_z_o); errors++;
        end
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d got %0d", $time, e.status, status_o); errors++;
        end
      end
    end
    if (done_o || (start && !busy)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_threshold(logic [9:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_THRESHOLD;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    thr_model = value;
  endtask

  // Present one item, hold until taken, then maybe drop start for a while
  task automatic send_matrix(logic signed [15:0] m [6], bit known, angles_t typed);
    start <= 1'b1;
    col1_x_i <= m[0]; col1_y_i <= m[1]; col1_z_i <= m[2];
    col3_x_i <= m[3]; col3_y_i <= m[4]; col3_z_i <= m[5];
    do @(posedge clk_i); while (busy);
    expected_angles.push_back(known ? typed : predict_angles(m));
    if (!no_idle && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] to_q14(real v);
    int t;
    t = $rtoi(v * 16384.0);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return 16'(t);
  endfunction

  function automatic real rand_angle();
    return ($urandom_range(0, 20000) / 10000.0 - 1.0) * 1.6;
  endfunction

  // Mostly true rotation matrices, the rest raw noise and zero columns
  task automatic random_items(int n);
    logic signed [15:0] m [6];
    real ax, ay, az, cx, sx, cy, sy, cz, sz;
    for (int it = 0; it < n; it++) begin
      no_idle = (it >= n / 4 && it < n / 2);
      if ($urandom_range(0, 99) < 70) begin
        ax = rand_angle(); ay = rand_angle(); az = rand_angle();
        cx = $cos(ax); sx = $sin(ax); cy = $cos(ay); sy = $sin(ay);
        cz = $cos(az); sz = $sin(az);
        m[0] = to_q14(cz * cy); m[1] = to_q14(sz * cy); m[2] = to_q14(-sy);
        m[3] = to_q14(cz * sy * cx + sz * sx);
        m[4] = to_q14(sz * sy * cx - cz * sx);
        m[5] = to_q14(cy * cx);
      end else begin
        foreach (m[f]) m[f] = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 9) == 0) begin
          m[3] = '0; m[4] = '0; m[5] = '0;
        end
      end
      if (it == n / 2) drain();
      send_matrix(m, 1'b0, '0);
    end
    no_idle = 0;
  endtask

  dir_row_t dir_tab [13];

  initial begin
    angles_t typed;
    rst_ni = 1'b0; start = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; thr_model = 10'd1;
    col1_x_i = '0; col1_y_i = '0; col1_z_i = '0;
    col3_x_i = '0; col3_y_i = '0; col3_z_i = '0;
    dir_tab = '{
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, ST_X1_LOW},
      '{'{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767},
        1, ST_X1_LOW},
      '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, ST_YZ_NULL},
      '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 0, ST_OK},
      '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
        0, ST_OK},
      '{'{16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
        0, ST_OK},
      '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 0, ST_OK},
      '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, -16'sd100}, 0, ST_OK},
      '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384}, 0, ST_OK},
      '{'{16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 0, ST_OK},
      '{'{16'sd11585, 16'sd0, -16'sd11585, 16'sd11585, 16'sd0, 16'sd11585}, 0, ST_OK},
      '{'{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1}, 0, ST_OK},
      '{'{16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1}, 0, ST_OK}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_threshold(10'd1);

    // Directed table: error rows carry their status, the rest go to the predictor
    foreach (dir_tab[n]) begin
      typed = '0;
      typed.status = dir_tab[n].status;
      send_matrix(dir_tab[n].m, dir_tab[n].known, typed);
    end
    drain();

    // Directed table again at threshold 0, then random phases across threshold settings, extremes included
    write_threshold(10'd0);
    foreach (dir_tab[n]) send_matrix(dir_tab[n].m, 1'b0, '0);
    random_items(300);
    drain();
    write_threshold(10'd1023);
    random_items(300);
    drain();
    write_threshold(10'($urandom_range(2, 64)));
    random_items(300);
    drain();
    write_threshold(10'd1);
    random_items(600);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
